### design/sapq_pkg.sv
package sapq_pkg;

	localparam int DEPTH = 16;
	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	localparam logic MODE_INSERT = 1'b0;
	localparam logic MODE_DELETE = 1'b1;

	localparam logic [1:0] STAT_OK    = 2'd0;
	localparam logic [1:0] STAT_FULL  = 2'd1;
	localparam logic [1:0] STAT_EMPTY = 2'd2;

	typedef struct packed {
		logic               mode;
		logic signed [31:0] value;
	} in_item_t;

	typedef struct packed {
		logic signed [31:0] removed_value;
		logic [1:0]         status;
		logic [4:0]         occupancy;
	} out_item_t;

endpackage

### design/sapq_engine.sv
module sapq_engine import sapq_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      item_valid,
	output logic      item_stall,
	input  in_item_t  item,
	output logic      res_valid,
	input  logic      res_take,
	output out_item_t res
);

	localparam int SUM_W = CNT_W + 1;

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_DEL  = 3'd1;
	localparam logic [2:0] S_INS  = 3'd2;
	localparam logic [2:0] S_FIN  = 3'd3;
	localparam logic [2:0] S_RES  = 3'd4;

	// circular store, one write and one registered read port
	logic signed [31:0] mem [DEPTH];
	logic signed [31:0] rd_data_q;

	logic [2:0]         state_q;
	logic [PTR_W-1:0]   head_q;
	logic [CNT_W-1:0]   count_q;
	logic [CNT_W-1:0]   k_q;
	logic signed [31:0] value_q;
	out_item_t          res_q;

	logic               we;
	logic               re;
	logic [PTR_W-1:0]   wa;
	logic [PTR_W-1:0]   ra;
	logic signed [31:0] wd;
	logic               accept;
	logic               shift_up;

	function automatic logic [PTR_W-1:0] slot(input logic [PTR_W-1:0] h,
		input logic [CNT_W-1:0] off);
		logic [SUM_W-1:0] sum;
		sum = SUM_W'(h) + SUM_W'(off);
		if (sum >= SUM_W'(DEPTH)) begin
			sum = sum - SUM_W'(DEPTH);
		end
		return sum[PTR_W-1:0];
	endfunction

	assign accept     = item_valid && (state_q == S_IDLE);
	assign item_stall = (state_q != S_IDLE);
	assign res_valid  = (state_q == S_RES);
	assign res        = res_q;
	assign shift_up   = (rd_data_q > value_q);

	// Port control. In the shift loop the read of offset k-2 goes out while
	// offset k is written, so the two never touch the same entry.
	always_comb begin
		we = 1'b0;
		re = 1'b0;
		wa = slot(head_q, k_q);
		ra = slot(head_q, k_q - CNT_W'(2));
		wd = value_q;
		unique case (state_q)
			S_IDLE: begin
				if (accept && item.mode == MODE_DELETE) begin
					re = (count_q != '0);
					ra = head_q;
				end else if (accept) begin
					if (count_q == '0) begin
						we = 1'b1;
						wa = head_q;
						wd = item.value;
					end else if (count_q != CNT_W'(DEPTH)) begin
						re = 1'b1;
						ra = slot(head_q, count_q - CNT_W'(1));
					end
				end
			end
			S_INS: begin
				we = 1'b1;
				if (shift_up) begin
					wd = rd_data_q;
					re = (k_q >= CNT_W'(2));
				end
			end
			S_FIN: begin
				we = 1'b1;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[wa] <= wd;
		end
		if (re) begin
			rd_data_q <= mem[ra];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			head_q  <= '0;
			count_q <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (item.mode == MODE_DELETE) begin
							state_q <= (count_q == '0) ? S_RES : S_DEL;
						end else if (count_q == CNT_W'(DEPTH) || count_q == '0) begin
							state_q <= S_RES;
							if (count_q == '0) begin
								count_q <= CNT_W'(1);
							end
						end else begin
							state_q <= S_INS;
						end
					end
				end
				S_DEL: begin
					head_q  <= slot(head_q, CNT_W'(1));
					count_q <= count_q - CNT_W'(1);
					state_q <= S_RES;
				end
				S_INS: begin
					if (!shift_up) begin
						count_q <= count_q + CNT_W'(1);
						state_q <= S_RES;
					end else if (k_q == CNT_W'(1)) begin
						state_q <= S_FIN;
					end
				end
				S_FIN: begin
					count_q <= count_q + CNT_W'(1);
					state_q <= S_RES;
				end
				S_RES: begin
					if (res_take) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				value_q <= item.value;
				k_q     <= count_q;
				res_q.removed_value <= '0;
				res_q.status        <= STAT_OK;
				res_q.occupancy     <= 5'(count_q);
				if (item.mode == MODE_DELETE && count_q == '0) begin
					res_q.status <= STAT_EMPTY;
				end else if (item.mode == MODE_INSERT && count_q == CNT_W'(DEPTH)) begin
					res_q.status <= STAT_FULL;
				end else if (item.mode == MODE_INSERT && count_q == '0) begin
					res_q.occupancy <= 5'(1);
				end
			end
			S_DEL: begin
				res_q.removed_value <= rd_data_q;
				res_q.occupancy     <= 5'(count_q - CNT_W'(1));
			end
			S_INS: begin
				if (shift_up) begin
					k_q <= k_q - CNT_W'(1);
				end
				res_q.occupancy <= 5'(count_q + CNT_W'(1));
			end
			S_FIN: begin
				res_q.occupancy <= 5'(count_q + CNT_W'(1));
			end
			default: begin
			end
		endcase
	end

endmodule

### design/sorted_array_priority_queue_unit.sv
// channel  dir  handshake                  beat
// item     in   item_valid / item_stall    in_item_t  {mode, value}
// result   out  result_valid / result_stall out_item_t {removed_value, status, occupancy}
//
// From the accepting edge to the edge that loads the result register: a refused insert or
// delete, or an insert into an empty queue, goes straight to the result; a delete reads the
// head, then updates; an insert does one memory read-modify-write per stored entry larger
// than the new value, then writes it. The beat is valid on result after that edge, where the
// engine is idle again and can take the next item. Reset clears the state, head, count and
// result valid flag only; the store needs no clearing pass. item_stall is high while an item
// is in the engine; a stalled result waits in the result register while the next item runs.
module sorted_array_priority_queue_unit import sapq_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      item_valid,
	output logic      item_stall,
	input  in_item_t  item,
	output logic      result_valid,
	input  logic      result_stall,
	output out_item_t result
);

	logic      eng_res_valid;
	logic      eng_res_take;
	out_item_t eng_res;

	logic      result_valid_q;
	out_item_t result_q;

	// engine: store, pointers and the shift sequencer
	sapq_engine u_engine (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_stall (item_stall),
		.item       (item),
		.res_valid  (eng_res_valid),
		.res_take   (eng_res_take),
		.res        (eng_res)
	);

	// result register loads when empty or when its beat leaves this cycle
	assign eng_res_take = eng_res_valid && (!result_valid_q || !result_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (eng_res_take) begin
			result_valid_q <= 1'b1;
		end else if (!result_stall) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (eng_res_take) begin
			result_q <= eng_res;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

endmodule
